// ----- rtl/pcns_pkg.sv -----
`timescale 1ns / 1ps

package pcns_pkg;

  // Fixed widths of the data path.
  localparam int LANES     = 5;   // z-window lanes in one row
  localparam int CW        = 7;   // a grid size or a wrapped coordinate
  localparam int OFF_W     = 3;   // a window offset, 0 to 2*reach
  localparam int XY_W      = 14;  // x*ny + y
  localparam int IDX_W     = 18;  // linear cell index
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELLS_X,
    CFG_CELLS_Y,
    CFG_CELLS_Z,
    CFG_REACH
  } cfg_reg_e;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [5:0] cell_z;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] neighbor_lane0;
    logic [IDX_W-1:0] neighbor_lane1;
    logic [IDX_W-1:0] neighbor_lane2;
    logic [IDX_W-1:0] neighbor_lane3;
    logic [IDX_W-1:0] neighbor_lane4;
    logic [LANES-1:0] lane_valid;
    logic             row_last;
  } out_word_t;

  // Effective grid settings, already clamped to their legal ranges.
  typedef struct packed {
    coord_t     nx;
    coord_t     ny;
    coord_t     nz;
    logic [1:0] reach;
  } grid_t;

  // One classified central cell, as the row generator needs it.
  typedef struct packed {
    coord_t [LANES-1:0] xs;
    coord_t [LANES-1:0] ys;
    coord_t [LANES-1:0] zs;
    logic   [LANES-1:0] x_self;
    logic   [LANES-1:0] y_self;
    logic   [LANES-1:0] z_self;
    logic   [LANES-1:0] lane_en;
    logic   [OFF_W-1:0] last_off;
  } row_job_t;

endpackage

// ----- rtl/pcns_stream_if.sv -----
`timescale 1ns / 1ps

interface pcns_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pcns_front.sv -----
`timescale 1ns / 1ps

module pcns_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcns_pkg::grid_t    grid_i,
  input  logic               in_valid_i,
  input  pcns_pkg::in_word_t in_data_i,
  output logic               in_ready_o,
  output logic               job_valid_o,
  output pcns_pkg::row_job_t job_o,
  input  logic               job_ready_i
);
  import pcns_pkg::*;

  logic   hold_valid_q;
  coord_t cx_q, cy_q, cz_q;
  coord_t cx_d, cy_d, cz_d;
  logic   accept;

  // True modulo of c + off - r for a coordinate already below n.
  function automatic coord_t wrap_coord(coord_t c, logic [OFF_W-1:0] off, logic [1:0] r,
                                        coord_t n);
    logic signed [CW+2:0] v;
    logic signed [CW+2:0] ns;
    ns = signed'({3'b000, n});
    v  = signed'({3'b000, c}) + signed'({7'b0, off}) - signed'({8'b0, r});
    if (v < 0) v = v + ns;
    if (v < 0) v = v + ns;
    if (v >= ns) v = v - ns;
    if (v >= ns) v = v - ns;
    return v[CW-1:0];
  endfunction

  function automatic coord_t clamp_coord(logic [5:0] c, coord_t n);
    return ({1'b0, c} >= n) ? n - 7'd1 : {1'b0, c};
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !hold_valid_q || job_ready_i;
  assign job_valid_o = hold_valid_q;

  assign cx_d = clamp_coord(in_data_i.cell_x, grid_i.nx);
  assign cy_d = clamp_coord(in_data_i.cell_y, grid_i.ny);
  assign cz_d = clamp_coord(in_data_i.cell_z, grid_i.nz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (accept) begin
      hold_valid_q <= 1'b1;
    end else if (job_ready_i) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
    end
  end

  always_comb begin
    job_o.last_off = {grid_i.reach, 1'b0};
    for (int l = 0; l < LANES; l++) begin
      job_o.xs[l]      = wrap_coord(cx_q, OFF_W'(l), grid_i.reach, grid_i.nx);
      job_o.ys[l]      = wrap_coord(cy_q, OFF_W'(l), grid_i.reach, grid_i.ny);
      job_o.zs[l]      = wrap_coord(cz_q, OFF_W'(l), grid_i.reach, grid_i.nz);
      job_o.x_self[l]  = (job_o.xs[l] == cx_q);
      job_o.y_self[l]  = (job_o.ys[l] == cy_q);
      job_o.z_self[l]  = (job_o.zs[l] == cz_q);
      job_o.lane_en[l] = (OFF_W'(l) <= {grid_i.reach, 1'b0});
    end
  end

endmodule

// ----- rtl/pcns_queue.sv -----
`timescale 1ns / 1ps

module pcns_queue #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  T     in_data_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output T     out_data_o,
  input  logic out_ready_i
);
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  T           slot_q [2];
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= in_data_i;
  end

endmodule

// ----- rtl/pcns_back.sv -----
`timescale 1ns / 1ps

module pcns_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcns_pkg::grid_t     grid_i,
  input  logic                job_valid_i,
  input  pcns_pkg::row_job_t  job_i,
  output logic                job_ready_o,
  output logic                out_valid_o,
  output pcns_pkg::out_word_t out_data_o,
  input  logic                out_ready_i
);
  import pcns_pkg::*;

  localparam int PROD_W = XY_W + CW;

  logic             en, issue, row_last_c, self_xy;
  logic [OFF_W-1:0] ox_q, oy_q;

  // Stage 1: x*ny + y of the row.
  logic               s1_valid_q, s1_last_q;
  logic [XY_W-1:0]    s1_xy_q;
  coord_t [LANES-1:0] s1_zs_q;
  logic [LANES-1:0]   s1_mask_q;

  // Stage 2: row base (x*ny + y)*nz.
  logic               s2_valid_q, s2_last_q;
  logic [IDX_W-1:0]   s2_base_q;
  coord_t [LANES-1:0] s2_zs_q;
  logic [LANES-1:0]   s2_mask_q;
  logic [PROD_W-1:0]  prod;

  logic             out_valid_q;
  out_word_t        out_q;
  logic [IDX_W-1:0] lane_d [LANES];

  assign en          = !out_valid_q || out_ready_i;
  assign issue       = job_valid_i && en;
  assign row_last_c  = (ox_q == job_i.last_off) && (oy_q == job_i.last_off);
  assign job_ready_o = en && row_last_c;
  assign self_xy     = job_i.x_self[ox_q] && job_i.y_self[oy_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= '0;
      oy_q <= '0;
    end else if (issue) begin
      if (oy_q == job_i.last_off) begin
        oy_q <= '0;
        ox_q <= (ox_q == job_i.last_off) ? '0 : ox_q + 3'd1;
      end else begin
        oy_q <= oy_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= job_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign prod = PROD_W'(s1_xy_q) * PROD_W'(grid_i.nz);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_d[l] = s2_mask_q[l] ? s2_base_q + IDX_W'(s2_zs_q[l]) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_xy_q   <= XY_W'(job_i.xs[ox_q]) * XY_W'(grid_i.ny) + XY_W'(job_i.ys[oy_q]);
      s1_zs_q   <= job_i.zs;
      s1_mask_q <= job_i.lane_en & ~(self_xy ? job_i.z_self : '0);
      s1_last_q <= row_last_c;

      s2_base_q <= prod[IDX_W-1:0];
      s2_zs_q   <= s1_zs_q;
      s2_mask_q <= s1_mask_q;
      s2_last_q <= s1_last_q;

      out_q.neighbor_lane0 <= lane_d[0];
      out_q.neighbor_lane1 <= lane_d[1];
      out_q.neighbor_lane2 <= lane_d[2];
      out_q.neighbor_lane3 <= lane_d[3];
      out_q.neighbor_lane4 <= lane_d[4];
      out_q.lane_valid     <= s2_mask_q;
      out_q.row_last       <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/periodic_cell_neighbor_stencil_unit.sv -----
`timescale 1ns / 1ps

// Periodic cell neighbour stencil.
// The in_i channel takes one word per central cell (cell_x, cell_y, cell_z).
// For every such word the out_o channel delivers one word per
// (dx, dy) row of the neighbourhood, dx outer and dy inner: 9 words when the
// reach is 1, 25 when it is 2. Each output word holds the linear indices of
// the z-window in five lanes, a lane mask that drops the centre and unused
// lanes, and row_last on the final row of the cell.
// The first row passes the front register, the queue and the back-end stages
// before it reaches the output register; rows then follow at one per cycle
// while the receiver takes them; the output port sets the rate. A two-entry
// queue between the classifying front end and the row generator lets the
// next cell be taken while the current one is still being expanded.
// When the receiver stalls, the row pipeline holds and the queue fills; the
// input then stalls too and nothing is lost. Reset empties all stages and
// loads the grid registers with 8 x 8 x 8 cells and a reach of 2.
// Configuration writes through cfg_we_i/cfg_idx_i/cfg_data_i must only be made
// while the block is idle; the block itself does not enforce this.
module periodic_cell_neighbor_stencil_unit #(
  parameter int MAX_CELLS_PER_AXIS = 64,
  parameter int MAX_REACH          = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcns_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcns_pkg::CFG_W-1:0]      cfg_data_i,
  pcns_stream_if.sink                     in_i,
  pcns_stream_if.source                   out_o
);
  import pcns_pkg::*;

  // Largest usable reach: five lanes allow at most two.
  localparam int RMAX = (MAX_REACH < 2) ? MAX_REACH : 2;

  coord_t     cells_x_q, cells_y_q, cells_z_q;
  logic [1:0] reach_q;
  grid_t      grid;

  logic     job_valid, job_ready;
  row_job_t job;
  logic     q_valid, q_ready;
  row_job_t q_job;

  // Register file: a write lands on the edge at which the enable is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= 7'd8;
      cells_y_q <= 7'd8;
      cells_z_q <= 7'd8;
      reach_q   <= 2'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_CELLS_X: cells_x_q <= cfg_data_i;
        CFG_CELLS_Y: cells_y_q <= cfg_data_i;
        CFG_CELLS_Z: cells_z_q <= cfg_data_i;
        CFG_REACH:   reach_q   <= cfg_data_i[1:0];
      endcase
    end
  end

  // A size of zero counts as one cell; a size above the maximum is limited.
  function automatic coord_t clamp_size(coord_t n);
    if (n == '0) return 7'd1;
    if ({2'b00, n} > 9'(MAX_CELLS_PER_AXIS)) return CW'(MAX_CELLS_PER_AXIS);
    return n;
  endfunction

  always_comb begin
    grid.nx = clamp_size(cells_x_q);
    grid.ny = clamp_size(cells_y_q);
    grid.nz = clamp_size(cells_z_q);
    if (reach_q == 2'd0) begin
      grid.reach = 2'd1;
    end else if ({1'b0, reach_q} > 3'(RMAX)) begin
      grid.reach = 2'(RMAX);
    end else begin
      grid.reach = reach_q;
    end
  end

  // Front end: clamps the coordinates and works out the wrapped coordinates per axis.
  pcns_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_i      (grid),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_i.data),
    .in_ready_o  (in_i.ready),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  // Decoupling queue between classification and row generation.
  pcns_queue #(
    .T (row_job_t)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (job_valid),
    .in_data_i   (job),
    .in_ready_o  (job_ready),
    .out_valid_o (q_valid),
    .out_data_o  (q_job),
    .out_ready_i (q_ready)
  );

  // Back end: steps through the rows and forms the linear indices.
  pcns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_i      (grid),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_ready_o (q_ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .out_ready_i (out_o.ready)
  );

  // A lane that is masked off carries a zero index.
  a_masked_lanes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      (out_o.data.lane_valid[0] || out_o.data.neighbor_lane0 == '0) &&
      (out_o.data.lane_valid[1] || out_o.data.neighbor_lane1 == '0) &&
      (out_o.data.lane_valid[2] || out_o.data.neighbor_lane2 == '0) &&
      (out_o.data.lane_valid[3] || out_o.data.neighbor_lane3 == '0) &&
      (out_o.data.lane_valid[4] || out_o.data.neighbor_lane4 == '0))
    else $error("masked lane carries a non-zero index");

  // With a reach of one only the first three lanes can be in use.
  a_reach_one_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && grid.reach == 2'd1) |-> (out_o.data.lane_valid[4:3] == 2'b00))
    else $error("outer lanes valid with a reach of one");

  // The outer lanes of a row never share the centre's z, so they stay valid
  // unless the grid is too short in z to hold the whole window.
  a_outer_lane_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && grid.reach == 2'd2 && grid.nz > 7'd4) |->
      (out_o.data.lane_valid[0] && out_o.data.lane_valid[4]))
    else $error("outer lane dropped on a long z axis");

endmodule

// ----- test/periodic_cell_neighbor_stencil_unit_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the periodic cell neighbour stencil.
module periodic_cell_neighbor_stencil_unit_test;
  import pcns_pkg::*;

  localparam int CELL_LIMIT  = 64;      // MAX_CELLS_PER_AXIS of the instance
  localparam int REACH_LIMIT = 2;       // MAX_REACH of the instance
  localparam int CYCLE_LIMIT = 200000;  // many times the slowest correct run
  localparam int SETTLE      = 8;       // cycles of quiet after the last row
  localparam int HOLD_AT     = 60;      // centres accepted before the long stall
  localparam int HOLD_CYCLES = 400;
  localparam int GRIDS       = 6;
  localparam int CENTRES_PER_GRID = 25;
  localparam int N_DIRECTED  = 20;

  // One row of the directed table. When regrid is set the grid registers are
  // rewritten before the centre is sent. When typed is set the first row of
  // the centre is taken from first_row, worked out by hand; every other row
  // comes from the stencil predictor below.
  typedef struct packed {
    logic       regrid;
    logic [6:0] gx;
    logic [6:0] gy;
    logic [6:0] gz;
    logic [1:0] greach;
    in_word_t   centre;
    logic       typed;
    out_word_t  first_row;
  } stencil_case_t;

  localparam stencil_case_t DIRECTED_CASES [N_DIRECTED] = '{
    // Reset grid of 8 x 8 x 8 with reach 2: both corners, then an oversized
    // coordinate that must saturate onto the far corner.
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd0, 6'd0, 6'd0}, 1'b1,
      '{18'd438, 18'd439, 18'd432, 18'd433, 18'd434, 5'b11111, 1'b0}},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd7, 6'd7, 6'd7}, 1'b1,
      '{18'd365, 18'd366, 18'd367, 18'd360, 18'd361, 5'b11111, 1'b0}},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd63, 6'd63, 6'd63}, 1'b1,
      '{18'd365, 18'd366, 18'd367, 18'd360, 18'd361, 5'b11111, 1'b0}},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd3, 6'd4, 6'd5}, 1'b0, '0},
    // A single cell: every lane in use is the centre or a wrapped copy of it.
    '{1'b1, 7'd1, 7'd1, 7'd1, 2'd1, '{6'd0, 6'd0, 6'd0}, 1'b1,
      '{18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 5'b00000, 1'b0}},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd63, 6'd0, 6'd63}, 1'b0, '0},
    // Largest grid: the far corner reaches the top of the index range.
    '{1'b1, 7'd64, 7'd64, 7'd64, 2'd2, '{6'd63, 6'd63, 6'd63}, 1'b1,
      '{18'd253821, 18'd253822, 18'd253823, 18'd253760, 18'd253761, 5'b11111, 1'b0}},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd42, 6'd21, 6'd63}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd1, 6'd62, 6'd0}, 1'b0, '0},
    // Zero sizes and a zero reach are taken as one.
    '{1'b1, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd5, 6'd5, 6'd5}, 1'b1,
      '{18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 5'b00000, 1'b0}},
    // Oversized grid and reach saturate to 64 cells and a reach of 2.
    '{1'b1, 7'd127, 7'd127, 7'd127, 2'd3, '{6'd63, 6'd63, 6'd63}, 1'b1,
      '{18'd253821, 18'd253822, 18'd253823, 18'd253760, 18'd253761, 5'b11111, 1'b0}},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd32, 6'd16, 6'd8}, 1'b0, '0},
    // A 2 x 2 x 2 grid with reach 2 folds the window onto itself, so the
    // same neighbour shows up several times and self copies are dropped.
    '{1'b1, 7'd2, 7'd2, 7'd2, 2'd2, '{6'd0, 6'd0, 6'd0}, 1'b1,
      '{18'd0, 18'd1, 18'd0, 18'd1, 18'd0, 5'b01010, 1'b0}},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd1, 6'd1, 6'd1}, 1'b0, '0},
    // Reach 1 on uneven grids leaves lanes 3 and 4 unused.
    '{1'b1, 7'd3, 7'd5, 7'd1, 2'd1, '{6'd2, 6'd4, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b1, 7'd64, 7'd1, 7'd64, 2'd1, '{6'd63, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, 7'd0, 2'd0, '{6'd0, 6'd63, 6'd63}, 1'b0, '0},
    '{1'b1, 7'd8, 7'd8, 7'd8, 2'd1, '{6'd4, 6'd4, 6'd4}, 1'b0, '0}
  };

  // Grid settings of the random phases. Phases 2 and 5 draw their own.
  localparam logic [6:0] PHASE_X [GRIDS] = '{7'd64, 7'd5, 7'd0, 7'd1, 7'd127, 7'd0};
  localparam logic [6:0] PHASE_Y [GRIDS] = '{7'd64, 7'd9, 7'd0, 7'd64, 7'd0, 7'd0};
  localparam logic [6:0] PHASE_Z [GRIDS] = '{7'd64, 7'd4, 7'd0, 7'd2, 7'd33, 7'd0};
  localparam logic [1:0] PHASE_R [GRIDS] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd3, 2'd0};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  pcns_stream_if #(.T(in_word_t))  centre_ch ();
  pcns_stream_if #(.T(out_word_t)) row_ch ();

  periodic_cell_neighbor_stencil_unit #(
    .MAX_CELLS_PER_AXIS(CELL_LIMIT),
    .MAX_REACH         (REACH_LIMIT)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_i (centre_ch),
    .out_o(row_ch)
  );

  // The bench's own copy of the grid registers, as last written. The
  // clamping of sizes and reach is applied only when centres are picked or expanded.
  logic [6:0] grid_x     = 7'd8;
  logic [6:0] grid_y     = 7'd8;
  logic [6:0] grid_z     = 7'd8;
  logic [1:0] grid_reach = 2'd2;

  // Rows still owed by the block, oldest first.
  out_word_t rows_due [$];

  int mismatches     = 0;
  int centres_sent   = 0;
  int rows_checked   = 0;
  int grids_used     = 1;
  int cycle_count    = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  bit calm           = 1'b0;   // no idling on either side while set

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d rows outstanding",
               cycle_count, rows_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int eff_size(logic [6:0] raw);
    if (raw == 7'd0) return 1;
    if (raw > CELL_LIMIT) return CELL_LIMIT;
    return int'(raw);
  endfunction

  // True modulo of c + (off - r) on an axis of n cells.
  function automatic int wrap_axis(int c, int off, int r, int n);
    return (c + 4 * n + off - r) % n;
  endfunction

  function automatic logic [5:0] pick_coord(logic [6:0] raw);
    int n;
    n = eff_size(raw);
    // Mostly coordinates on the grid, the rest anywhere in the field so that
    // saturation keeps being exercised.
    if ($urandom_range(0, 3) != 0) return 6'($urandom_range(0, n - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // Stencil predictor: queues every row that one centre word must produce.
  task automatic expand_centre(input in_word_t w, input bit typed,
                               input out_word_t typed_row);
    int nx, ny, nz, r, span, cx, cy, cz, x, y, z;
    logic [IDX_W-1:0] lane [LANES];
    out_word_t row;
    bit first;
    nx = eff_size(grid_x);
    ny = eff_size(grid_y);
    nz = eff_size(grid_z);
    r  = (grid_reach == 2'd0) ? 1 : int'(grid_reach);
    if (r > REACH_LIMIT) r = REACH_LIMIT;
    if (r > 2) r = 2;
    span = 2 * r + 1;
    cx = (int'(w.cell_x) >= nx) ? nx - 1 : int'(w.cell_x);
    cy = (int'(w.cell_y) >= ny) ? ny - 1 : int'(w.cell_y);
    cz = (int'(w.cell_z) >= nz) ? nz - 1 : int'(w.cell_z);
    first = 1'b1;
    for (int ox = 0; ox < span; ox++) begin
      x = wrap_axis(cx, ox, r, nx);
      for (int oy = 0; oy < span; oy++) begin
        y = wrap_axis(cy, oy, r, ny);
        row = '0;
        for (int oz = 0; oz < LANES; oz++) begin
          lane[oz] = '0;
          if (oz < span) begin
            z = wrap_axis(cz, oz, r, nz);
            // The centre itself, or a wrapped copy of it, is not a neighbour.
            if (!(x == cx && y == cy && z == cz)) begin
              lane[oz] = IDX_W'((x * ny + y) * nz + z);
              row.lane_valid[oz] = 1'b1;
            end
          end
        end
        row.neighbor_lane0 = lane[0];
        row.neighbor_lane1 = lane[1];
        row.neighbor_lane2 = lane[2];
        row.neighbor_lane3 = lane[3];
        row.neighbor_lane4 = lane[4];
        row.row_last = (ox == span - 1) && (oy == span - 1);
        rows_due.push_back((first && typed) ? typed_row : row);
        first = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [IDX_W-1:0] got,
                             input logic [IDX_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("row %0d %s got %0d expected %0d",
                                rows_checked, name, got, want));
  endtask

  task automatic check_row(input out_word_t got);
    out_word_t want;
    rows_checked++;
    if (rows_due.size() == 0) begin
      report_mismatch($sformatf("row %0d arrived with no row expected", rows_checked));
      return;
    end
    want = rows_due.pop_front();
    check_field("neighbor_lane0", got.neighbor_lane0, want.neighbor_lane0);
    check_field("neighbor_lane1", got.neighbor_lane1, want.neighbor_lane1);
    check_field("neighbor_lane2", got.neighbor_lane2, want.neighbor_lane2);
    check_field("neighbor_lane3", got.neighbor_lane3, want.neighbor_lane3);
    check_field("neighbor_lane4", got.neighbor_lane4, want.neighbor_lane4);
    check_field("lane_valid", IDX_W'(got.lane_valid), IDX_W'(want.lane_valid));
    check_field("row_last", IDX_W'(got.row_last), IDX_W'(want.row_last));
  endtask

  // Offers one centre word, with random gaps ahead of it unless calm, and leaves
  // valid high after acceptance so that back-to-back words need no gap between them.
  task automatic send_centre(input in_word_t w, input bit typed,
                             input out_word_t typed_row);
    while (!calm && $urandom_range(0, 99) < 14) begin
      centre_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    centre_ch.valid <= 1'b1;
    centre_ch.data  <= w;
    do @(posedge clk_i); while (!centre_ch.ready);
    centres_sent++;
    expand_centre(w, typed, typed_row);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Rewrites all four grid registers once the block has drained.
  task automatic set_grid(input logic [6:0] gx, input logic [6:0] gy,
                          input logic [6:0] gz, input logic [1:0] gr);
    centre_ch.valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    write_reg(CFG_CELLS_X, gx);
    write_reg(CFG_CELLS_Y, gy);
    write_reg(CFG_CELLS_Z, gz);
    write_reg(CFG_REACH, CFG_W'(gr));
    cfg_we_i   <= 1'b0;
    grid_x     = gx;
    grid_y     = gy;
    grid_z     = gz;
    grid_reach = gr;
    grids_used++;
  endtask

  // Receiver: random stalls, none while calm, and one long hold-off once
  // enough centres have gone in. During the hold-off the sender keeps
  // offering words, so the row queue fills and the input must stall.
  initial begin
    row_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && centres_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      row_ch.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 14);
    end
  end

  // Every accepted output word is checked against the oldest row owed.
  always @(posedge clk_i) begin
    if (rst_ni && row_ch.valid && row_ch.ready) check_row(row_ch.data);
  end

  initial begin
    logic [6:0] gx, gy, gz;
    logic [1:0] gr;
    in_word_t   w;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_CELLS_X;
    cfg_data_i      <= '0;
    centre_ch.valid <= 1'b0;
    centre_ch.data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: corners, saturation, degenerate and folded grids.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED_CASES[i].regrid)
        set_grid(DIRECTED_CASES[i].gx, DIRECTED_CASES[i].gy,
                 DIRECTED_CASES[i].gz, DIRECTED_CASES[i].greach);
      send_centre(DIRECTED_CASES[i].centre, DIRECTED_CASES[i].typed,
                  DIRECTED_CASES[i].first_row);
    end

    // Random part: a run of centres under each grid setting. Phase 2 runs
    // with no idling at all on either side.
    for (int p = 0; p < GRIDS; p++) begin
      gx = PHASE_X[p];
      gy = PHASE_Y[p];
      gz = PHASE_Z[p];
      gr = PHASE_R[p];
      if (p == 2 || p == 5) begin
        gx = 7'($urandom_range(1, 64));
        gy = 7'($urandom_range(1, 64));
        gz = 7'($urandom_range(1, 64));
        gr = 2'($urandom_range(1, 2));
      end
      set_grid(gx, gy, gz, gr);
      calm = (p == 2);
      for (int k = 0; k < CENTRES_PER_GRID; k++) begin
        w.cell_x = pick_coord(grid_x);
        w.cell_y = pick_coord(grid_y);
        w.cell_z = pick_coord(grid_z);
        send_centre(w, 1'b0, '0);
      end
      calm = 1'b0;
    end

    centre_ch.valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d centre words under %0d grid settings and compared %0d rows,",
             centres_sent, grids_used, rows_checked);
    $display("with a %0d-cycle output stall; %0d mismatches.", HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pcns_pkg.sv
rtl/pcns_stream_if.sv
rtl/pcns_front.sv
rtl/pcns_queue.sv
rtl/pcns_back.sv
rtl/periodic_cell_neighbor_stencil_unit.sv
test/periodic_cell_neighbor_stencil_unit_test.sv
